// File: hdl/hfn_pkg.sv
package hfn_pkg;

    localparam int GRID_STEP = 8;
    localparam int HEIGHT_W = 24;
    localparam int COMP_W = 25;
    localparam int MAG_W = 24;
    localparam int SQ_W = 48;
    localparam int SUM_W = 50;
    localparam int RAD_W = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W = 35;
    localparam int NUM_W = 48;
    localparam int DEN_W = 33;
    localparam int CMP_W = 50;
    localparam int NORM_W = 17;
    localparam int QUO_W = 17;
    localparam int VEC_N = 3;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 17;
    localparam int UNIT_LAT = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int TOTAL_LAT = 1 + 2 * UNIT_LAT;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 184;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [HEIGHT_W-1:0] height_t;

    localparam comp_t STEP_Q = comp_t'(GRID_STEP * 256);
    localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(32768);

endpackage

// File: hdl/heightmap_face_normals.sv
// terrain square face normals
//
// input channel s_axis: one terrain square per item, four corner heights in
// signed q16.8 on tdata and the last-square-of-rectangle mark on tlast
// output channel m_axis: one result item per input item, in order; three unit
// normals in signed q2.15 (top-left triangle, bottom-right triangle, square)
// and the truncated mean height, with tlast copied from the input item
//
// the pipe is one input stage, then the two triangle normalize units side by
// side and the square normalize unit after them, 54 stages each (squares,
// 32-stage bit-per-cycle square root, divider setup, 17-stage bit-per-cycle
// restoring divider, saturation)
// throughput is one item per cycle while m_axis_tready stays high
//
// reset clears every valid bit, so no item is shown until new input arrives
// when the receiver stalls with a result waiting, the whole pipeline holds;
// s_axis_tready drops and nothing is lost or repeated
module heightmap_face_normals (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // height_top_left, height_top_right, height_bottom_left, height_bottom_right
    input  logic [hfn_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // upper_normal_x/y/z, lower_normal_x/y/z, square_normal_x/y/z,
    // center_height, zero fill to 184 bits
    output logic [hfn_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);
    import hfn_pkg::*;

    logic en;
    logic vld_reg [TOTAL_LAT];

    height_t tl, tr, bl, br;
    logic signed [HEIGHT_W+1:0] hsum;
    logic signed [HEIGHT_W+1:0] hsum_adj;

    // input stage
    comp_t   up_vec_reg [VEC_N];
    comp_t   lo_vec_reg [VEC_N];
    height_t ctr_dl_reg  [2*UNIT_LAT+1];
    logic    last_dl_reg [2*UNIT_LAT+1];

    norm_t up_norm [VEC_N];
    norm_t lo_norm [VEC_N];
    norm_t sq_norm [VEC_N];
    comp_t sq_vec  [VEC_N];
    norm_t up_dl_reg [UNIT_LAT][VEC_N];
    norm_t lo_dl_reg [UNIT_LAT][VEC_N];

    // the whole pipe moves unless a finished result is waiting on the receiver
    assign en = !vld_reg[TOTAL_LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TOTAL_LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int s = 1; s < TOTAL_LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign tl = $signed(s_axis_tdata[23:0]);
    assign tr = $signed(s_axis_tdata[47:24]);
    assign bl = $signed(s_axis_tdata[71:48]);
    assign br = $signed(s_axis_tdata[95:72]);

    // mean height, divide by four truncating toward zero
    assign hsum = (HEIGHT_W+2)'(tl) + (HEIGHT_W+2)'(tr) + (HEIGHT_W+2)'(bl)
                  + (HEIGHT_W+2)'(br);
    assign hsum_adj = hsum + (hsum[HEIGHT_W+1] ? (HEIGHT_W+2)'(3) : (HEIGHT_W+2)'(0));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // top-left triangle (-(tr-tl), step, -(bl-tl))
            up_vec_reg[0] <= comp_t'(tl) - comp_t'(tr);
            up_vec_reg[1] <= STEP_Q;
            up_vec_reg[2] <= comp_t'(tl) - comp_t'(bl);
            // bottom-right triangle (bl-br, step, tr-br)
            lo_vec_reg[0] <= comp_t'(bl) - comp_t'(br);
            lo_vec_reg[1] <= STEP_Q;
            lo_vec_reg[2] <= comp_t'(tr) - comp_t'(br);
            ctr_dl_reg[0]  <= height_t'(hsum_adj >>> 2);
            last_dl_reg[0] <= s_axis_tlast;
            for (int s = 1; s <= 2*UNIT_LAT; s++)
            begin
                ctr_dl_reg[s]  <= ctr_dl_reg[s-1];
                last_dl_reg[s] <= last_dl_reg[s-1];
            end
        end
    end

    hfn_unit u_upper (
        .clk  (clk),
        .en   (en),
        .vec  (up_vec_reg),
        .norm (up_norm)
    );

    hfn_unit u_lower (
        .clk  (clk),
        .en   (en),
        .vec  (lo_vec_reg),
        .norm (lo_norm)
    );

    // square vector is the sum of the two rounded triangle normals
    always_comb
    begin
        for (int i = 0; i < VEC_N; i++)
            sq_vec[i] = comp_t'(up_norm[i]) + comp_t'(lo_norm[i]);
    end

    hfn_unit u_square (
        .clk  (clk),
        .en   (en),
        .vec  (sq_vec),
        .norm (sq_norm)
    );

    // triangle normals wait beside the square unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up_dl_reg[0] <= up_norm;
            lo_dl_reg[0] <= lo_norm;
            for (int s = 1; s < UNIT_LAT; s++)
            begin
                up_dl_reg[s] <= up_dl_reg[s-1];
                lo_dl_reg[s] <= lo_dl_reg[s-1];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_axis_tlast  = last_dl_reg[2*UNIT_LAT];
    assign m_axis_tdata  = {7'b0,
                            ctr_dl_reg[2*UNIT_LAT],
                            sq_norm[2], sq_norm[1], sq_norm[0],
                            lo_dl_reg[UNIT_LAT-1][2], lo_dl_reg[UNIT_LAT-1][1],
                            lo_dl_reg[UNIT_LAT-1][0],
                            up_dl_reg[UNIT_LAT-1][2], up_dl_reg[UNIT_LAT-1][1],
                            up_dl_reg[UNIT_LAT-1][0]};

endmodule

// File: hdl/hfn_sqrt.sv
module hfn_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [hfn_pkg::RAD_W-1:0]      radicand,
    output logic [hfn_pkg::ROOT_W-1:0]     root
);
    import hfn_pkg::*;

    // one root bit per stage, remainder and root travel down the pipe
    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS+1];
    logic [RAD_W-1:0]  rad_reg  [SQRT_STEPS+1];

    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign rad_reg[0]  = radicand;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        logic [REM_W-1:0]  cand;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            cand  = {rem_reg[i][REM_W-3:0], rad_reg[i][RAD_W-1:RAD_W-2]};
            trial = REM_W'({root_reg[i], 2'b01});
            if (cand >= trial)
            begin
                rem_next  = cand - trial;
                root_next = {root_reg[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cand;
                root_next = {root_reg[i][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                rad_reg[i+1]  <= {rad_reg[i][RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS];

endmodule

// File: hdl/hfn_unit.sv
module hfn_unit (
    input  logic            clk,
    input  logic            en,
    input  hfn_pkg::comp_t  vec  [3],
    output hfn_pkg::norm_t  norm [3]
);
    import hfn_pkg::*;

    // magnitude and sign
    logic [MAG_W-1:0] s1_mag_reg [VEC_N];
    logic             s1_neg_reg [VEC_N];
    // squares
    logic [SQ_W-1:0]  s2_sq_reg  [VEC_N];
    logic [MAG_W-1:0] s2_mag_reg [VEC_N];
    logic             s2_neg_reg [VEC_N];
    // sum of squares
    logic [SUM_W-1:0] s3_sum_reg;
    logic             s3_zero_reg;
    logic [MAG_W-1:0] s3_mag_reg [VEC_N];
    logic             s3_neg_reg [VEC_N];
    // side data beside the square root
    logic [MAG_W-1:0] rt_mag_reg  [SQRT_STEPS][VEC_N];
    logic             rt_neg_reg  [SQRT_STEPS][VEC_N];
    logic             rt_zero_reg [SQRT_STEPS];
    logic [ROOT_W-1:0] root;
    // divider lanes
    logic [CMP_W-1:0] dv_rem_reg  [DIV_STEPS+1][VEC_N];
    logic [QUO_W-1:0] dv_quo_reg  [DIV_STEPS+1][VEC_N];
    logic             dv_ovf_reg  [DIV_STEPS+1][VEC_N];
    logic             dv_neg_reg  [DIV_STEPS+1][VEC_N];
    logic [DEN_W-1:0] dv_den_reg  [DIV_STEPS+1];
    logic             dv_zero_reg [DIV_STEPS+1];
    norm_t            out_reg [VEC_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VEC_N; i++)
            begin
                s1_neg_reg[i] <= vec[i][COMP_W-1];
                s1_mag_reg[i] <= vec[i][COMP_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
                s2_sq_reg[i]  <= SQ_W'(s1_mag_reg[i]) * SQ_W'(s1_mag_reg[i]);
                s2_mag_reg[i] <= s1_mag_reg[i];
                s2_neg_reg[i] <= s1_neg_reg[i];
                s3_mag_reg[i] <= s2_mag_reg[i];
                s3_neg_reg[i] <= s2_neg_reg[i];
            end
            s3_sum_reg  <= SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
            s3_zero_reg <= (s2_mag_reg[0] == '0) && (s2_mag_reg[1] == '0)
                           && (s2_mag_reg[2] == '0);
        end
    end

    hfn_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({s3_sum_reg, 14'b0}),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_zero_reg[0] <= s3_zero_reg;
            for (int i = 0; i < VEC_N; i++)
            begin
                rt_mag_reg[0][i] <= s3_mag_reg[i];
                rt_neg_reg[0][i] <= s3_neg_reg[i];
            end
            for (int s = 1; s < SQRT_STEPS; s++)
            begin
                rt_zero_reg[s] <= rt_zero_reg[s-1];
                rt_mag_reg[s]  <= rt_mag_reg[s-1];
                rt_neg_reg[s]  <= rt_neg_reg[s-1];
            end
        end
    end

    // rounded quotient (mag * 2^23 + L) / 2L, overflow flags a result past 17 bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_den_reg[0]  <= {root, 1'b0};
            dv_zero_reg[0] <= rt_zero_reg[SQRT_STEPS-1];
            for (int i = 0; i < VEC_N; i++)
            begin
                dv_rem_reg[0][i] <= CMP_W'({rt_mag_reg[SQRT_STEPS-1][i], 23'b0})
                                    + CMP_W'(root);
                dv_ovf_reg[0][i] <= (CMP_W'({rt_mag_reg[SQRT_STEPS-1][i], 23'b0})
                                    + CMP_W'(root))
                                    >= (CMP_W'({root, 1'b0}) << QUO_W);
                dv_quo_reg[0][i] <= '0;
                dv_neg_reg[0][i] <= rt_neg_reg[SQRT_STEPS-1][i];
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int K = DIV_STEPS - 1 - j;
        logic [CMP_W-1:0] dsh;

        assign dsh = CMP_W'(dv_den_reg[j]) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                for (int i = 0; i < VEC_N; i++)
                begin
                    dv_ovf_reg[j+1][i] <= dv_ovf_reg[j][i];
                    dv_neg_reg[j+1][i] <= dv_neg_reg[j][i];
                    if (dv_rem_reg[j][i] >= dsh)
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dsh;
                        dv_quo_reg[j+1][i] <= dv_quo_reg[j][i] | (QUO_W'(1) << K);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_quo_reg[j+1][i] <= dv_quo_reg[j][i];
                    end
                end
            end
        end
    end

    // saturate, apply sign, zero vector points straight up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VEC_N; i++)
            begin
                logic [QUO_W-1:0] q;
                q = (dv_ovf_reg[DIV_STEPS][i] || dv_quo_reg[DIV_STEPS][i] > UNIT_ONE)
                    ? UNIT_ONE : dv_quo_reg[DIV_STEPS][i];
                if (dv_zero_reg[DIV_STEPS])
                    out_reg[i] <= (i == 1) ? norm_t'(UNIT_ONE) : '0;
                else if (dv_neg_reg[DIV_STEPS][i])
                    out_reg[i] <= norm_t'(~q + QUO_W'(1));
                else
                    out_reg[i] <= norm_t'(q);
            end
        end
    end

    assign norm = out_reg;

endmodule

// File: hdl/hfn_check.sv
module hfn_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hfn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tlast
);
    import hfn_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // no result shown once reset has been seen
    a_reset: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    // both triangle normals point up
    a_tri_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[33] && (m_axis_tdata[33:17] != '0)
        && !m_axis_tdata[84] && (m_axis_tdata[84:68] != '0))
        else $error("triangle normal y not positive");

    // fill bits stay clear and square y never points down
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[183:177] == '0) && !m_axis_tdata[135])
        else $error("bad fill or square normal y");

endmodule

bind heightmap_face_normals hfn_check u_check (.*);

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hfn_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1550;

    typedef struct packed {
        logic signed [NORM_W-1:0] ux, uy, uz;
        logic signed [NORM_W-1:0] lx, ly, lz;
        logic signed [NORM_W-1:0] sx, sy, sz;
        logic signed [HEIGHT_W-1:0] centre;
        logic last;
    } normals_t;

    // one directed square; has_known marks rows with a hand-typed expectation
    typedef struct {
        logic signed [HEIGHT_W-1:0] tl, tr, bl, br;
        logic last;
        bit has_known;
        normals_t known;
    } square_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    heightmap_face_normals dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    normals_t pending_normals[$];
    square_row_t rows[$];
    int fail_count = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // integer square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // scale a vector to unit length in q2.15, rounding half up in magnitude
    function automatic void unit_vector(input longint v[3], output longint o[3]);
        longint unsigned sq;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned quo;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            sq += mag * mag;
        end
        if (sq == 0)
        begin
            o[0] = 0;
            o[1] = 32768;
            o[2] = 0;
            return;
        end
        len = floor_sqrt(sq << 14);
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            quo = ((mag << 23) + len) / (len * 2);
            if (quo > 32768)
                quo = 32768;
            o[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
        end
    endfunction

    function automatic normals_t face_normals(input longint tl, tr, bl, br,
                                             input logic last);
        longint vu[3], vl[3], vs[3], nu[3], nl[3], ns[3];
        normals_t res;
        vu[0] = -(tr - tl);
        vu[1] = GRID_STEP * 256;
        vu[2] = -(bl - tl);
        vl[0] = bl - br;
        vl[1] = GRID_STEP * 256;
        vl[2] = tr - br;
        unit_vector(vu, nu);
        unit_vector(vl, nl);
        for (int i = 0; i < 3; i++)
            vs[i] = nu[i] + nl[i];
        unit_vector(vs, ns);
        res.ux = NORM_W'(nu[0]);
        res.uy = NORM_W'(nu[1]);
        res.uz = NORM_W'(nu[2]);
        res.lx = NORM_W'(nl[0]);
        res.ly = NORM_W'(nl[1]);
        res.lz = NORM_W'(nl[2]);
        res.sx = NORM_W'(ns[0]);
        res.sy = NORM_W'(ns[1]);
        res.sz = NORM_W'(ns[2]);
        // division truncates toward zero like the hardware mean
        res.centre = HEIGHT_W'((tl + tr + bl + br) / 4);
        res.last = last;
        return res;
    endfunction

    function automatic void add_row(input square_row_t r);
        rows.insert(rows.size(), r);
    endfunction

    // one field compare, counted on mismatch
    function automatic void check_field(input string name,
                                        input logic signed [HEIGHT_W-1:0] want,
                                        input logic signed [HEIGHT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s exp %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // tdata holds tl in the lowest bits, then tr, bl, br
    task automatic send_square(input logic signed [HEIGHT_W-1:0] tl, tr, bl, br,
                               input logic last);
        // bursty sender: sometimes pause before offering the item
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {br, bl, tr, tl};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_normals.insert(pending_normals.size(),
                               face_normals(tl, tr, bl, br, last));
    endtask

    function automatic logic signed [HEIGHT_W-1:0] random_height(int mode);
        case (mode)
            0: return HEIGHT_W'($urandom);
            1: return HEIGHT_W'($signed($urandom_range(0, 4095)) - 2048);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return HEIGHT_W'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    // receiver stalls on its own pattern: runs of ready, runs of stall
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            case ($urandom_range(0, 3))
                0: m_axis_tready <= 1'b0;
                default: m_axis_tready <= 1'b1;
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // checker: compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        normals_t got;
        normals_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            // unpack from lowest bits: ux first
            got.ux = m_axis_tdata[0*NORM_W +: NORM_W];
            got.uy = m_axis_tdata[1*NORM_W +: NORM_W];
            got.uz = m_axis_tdata[2*NORM_W +: NORM_W];
            got.lx = m_axis_tdata[3*NORM_W +: NORM_W];
            got.ly = m_axis_tdata[4*NORM_W +: NORM_W];
            got.lz = m_axis_tdata[5*NORM_W +: NORM_W];
            got.sx = m_axis_tdata[6*NORM_W +: NORM_W];
            got.sy = m_axis_tdata[7*NORM_W +: NORM_W];
            got.sz = m_axis_tdata[8*NORM_W +: NORM_W];
            got.centre = m_axis_tdata[9*NORM_W +: HEIGHT_W];
            got.last = m_axis_tlast;
            if (pending_normals.size() == 0)
            begin
                $error("unexpected result item, tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_normals[0];
                pending_normals.delete(0);
                check_field("upper_normal_x", want.ux, got.ux);
                check_field("upper_normal_y", want.uy, got.uy);
                check_field("upper_normal_z", want.uz, got.uz);
                check_field("lower_normal_x", want.lx, got.lx);
                check_field("lower_normal_y", want.ly, got.ly);
                check_field("lower_normal_z", want.lz, got.lz);
                check_field("square_normal_x", want.sx, got.sx);
                check_field("square_normal_y", want.sy, got.sy);
                check_field("square_normal_z", want.sz, got.sz);
                check_field("center_height", want.centre, got.centre);
                if (got.last !== want.last)
                begin
                    $error("last_out exp %0d got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        square_row_t row;
        normals_t flat;
        int mode;
        int drained;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flat square: all normals straight up, centre equals the height
        flat = '0;
        flat.uy = 32768;
        flat.ly = 32768;
        flat.sy = 32768;
        row = '{0, 0, 0, 0, 1'b0, 1, flat};
        add_row(row);
        flat.centre = 24'sh7FFFFF;
        flat.last = 1'b1;
        row = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1, flat};
        add_row(row);
        flat.centre = 24'sh800000;
        flat.last = 1'b0;
        row = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0, 1, flat};
        add_row(row);
        // steepest slopes in every direction, saturation of the components
        add_row('{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b1, 0, '0});
        add_row('{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 1'b0, 0, '0});
        add_row('{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0, 0, '0});
        add_row('{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1, 0, '0});
        add_row('{24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 0, '0});
        add_row('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 1'b0, 0, '0});
        // mean truncation toward zero on negative and positive sums
        add_row('{-24'sd1, -24'sd1, -24'sd1, 24'sd0, 1'b0, 0, '0});
        add_row('{24'sd1, 24'sd1, 24'sd1, 24'sd0, 1'b1, 0, '0});
        add_row('{-24'sd3, 24'sd0, 24'sd0, 24'sd0, 1'b0, 0, '0});
        // gentle slopes near one grid step
        add_row('{24'sd0, 24'sd2048, 24'sd0, 24'sd2048, 1'b0, 0, '0});
        add_row('{24'sd0, 24'sd0, 24'sd2048, 24'sd2048, 1'b0, 0, '0});
        add_row('{24'sd2048, 24'sd0, 24'sd0, -24'sd2048, 1'b1, 0, '0});
        add_row('{24'sd0, 24'sd1, -24'sd1, 24'sd0, 1'b0, 0, '0});
        // opposing triangles whose normals cancel in x and z, then a pair tilted alike
        add_row('{24'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 1'b0, 0, '0});
        add_row('{24'sh400000, 24'shC00000, 24'sh400000, 24'shC00000, 1'b1, 0, '0});

        foreach (rows[i])
        begin
            if (rows[i].has_known)
            begin
                if (face_normals(rows[i].tl, rows[i].tr, rows[i].bl, rows[i].br,
                                 rows[i].last) !== rows[i].known)
                begin
                    $error("directed row %0d table entry disagrees with predictor", i);
                    fail_count++;
                end
            end
            send_square(rows[i].tl, rows[i].tr, rows[i].bl, rows[i].br, rows[i].last);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = $urandom_range(0, 3);
            send_square(random_height(mode), random_height(mode),
                        random_height(mode), random_height(mode),
                        1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_normals.size() != 0)
            @(posedge clk);
        // let any stray result appear after the last expected one
        drained = 0;
        while (drained < 2 * TOTAL_LAT)
        begin
            @(posedge clk);
            drained++;
        end

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: heightmap_face_normals.f
hdl/hfn_pkg.sv
hdl/hfn_sqrt.sv
hdl/hfn_unit.sv
hdl/heightmap_face_normals.sv
hdl/hfn_check.sv
dv/testbench.sv
